/* hdl/crce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_pkg
// Shared constants, codes and payload types of the closed-loop spline
// evaluator.
// ----------------------------------------------------------------------------
package crce_pkg;

	localparam int MAX_POINTS  = 256;
	localparam int MAX_DIMS    = 16;
	localparam int EMIT_LIMIT  = 16;
	localparam int DIM_LIM     = (MAX_DIMS < EMIT_LIMIT) ? MAX_DIMS : EMIT_LIMIT;
	localparam int MIN_LOOP    = 3;
	localparam int COPY_COMPS  = 2;

	localparam int PT_W        = $clog2(MAX_POINTS);
	localparam int DIM_W       = $clog2(MAX_DIMS);
	localparam int ADDR_W      = PT_W + DIM_W;
	localparam int RAM_DEPTH   = MAX_POINTS * MAX_DIMS;

	localparam int VAL_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int SEG_W       = VAL_W - FRAC_W;
	localparam int CNT_W       = 9;
	localparam int DIMS_W      = 5;
	localparam int COMP_W      = 4;
	localparam int PIDX_W      = 8;
	localparam int DIMS_RESET  = 16;

	localparam int OUT_DEPTH   = 16;
	localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic {
		CFG_POINT_COUNT = 1'b0,
		CFG_DIMS        = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_SETUP,
		ST_ISSUE
	} state_t;

	typedef struct packed {
		op_t                      operation;
		logic [PIDX_W-1:0]        point_index;
		logic [COMP_W-1:0]        component_index;
		logic signed [VAL_W-1:0]  load_value;
		logic signed [VAL_W-1:0]  param;
	} in_item_t;

	typedef struct packed {
		logic [COMP_W-1:0]        out_component;
		logic signed [VAL_W-1:0]  out_value;
		logic                     last;
	} out_item_t;

	// four read ports: p0, p1, p2, p3 of the current component
	typedef struct packed {
		logic                     we;
		logic [ADDR_W-1:0]        waddr;
		logic [VAL_W-1:0]         wdata;
		logic [3:0][ADDR_W-1:0]   raddr;
	} ram_req_t;

	typedef struct packed {
		logic                     valid;
		logic [COMP_W-1:0]        comp;
		logic                     last;
		logic                     copy;
		logic [FRAC_W-1:0]        frac;
	} issue_t;

endpackage

/* hdl/closed_loop_catmull_rom_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_loop_catmull_rom_eval
// Closed-loop uniform Catmull-Rom evaluator over a store of control points.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per beat (cmd_valid / cmd_stall). A load writes one
//   component of one point into the store and returns nothing. An evaluate
//   returns dims beats (dims clamped to 1..16) on res (res_valid /
//   res_stall), component 0 first, with last set on the final one.
//   cfg_we / cfg_index / cfg_data write point_count (index 0) or dims
//   (index 1); write them only while the block is idle.
// Timing:
//   A load is written into the store as it is accepted. An evaluate holds
//   cmd through setup and the issue of all its components, and through the
//   bit-serial remainder unit when a negative parameter has to be wrapped.
//   Each read passes the registered store read, the spline pipeline and the
//   result buffer; after that one result per cycle while buffer slots are
//   free, set by the two dual-read copies of the store feeding four reads a cycle.
// Reset:
//   The store is swept to zero, one word a cycle, across all 4096 words
//   after reset; cmd stays stalled meanwhile, configuration writes are taken.
// Backpressure:
//   Results queue in a 16-entry buffer; reads are issued only against free
//   buffer slots, so a stalled receiver just pauses the component sequence.
// ----------------------------------------------------------------------------
module closed_loop_catmull_rom_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [crce_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  crce_pkg::in_item_t          cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output crce_pkg::out_item_t         res
);

	crce_pkg::ram_req_t                ram;
	crce_pkg::issue_t                  iss;
	logic [3:0][crce_pkg::VAL_W-1:0]   pts;
	logic                              spl_valid;
	crce_pkg::out_item_t               spl_item;

	crce_pkg::out_item_t               fifo_q [crce_pkg::OUT_DEPTH];
	logic [crce_pkg::OUT_PTR_W-1:0]    wp_q, rp_q;
	logic [crce_pkg::OUT_CNT_W-1:0]    fifo_cnt_q;
	logic [crce_pkg::OUT_CNT_W-1:0]    used_q;
	logic                              credit_ok;
	logic                              push, pop;

	assign credit_ok = (used_q < crce_pkg::OUT_CNT_W'(crce_pkg::OUT_DEPTH));
	assign push      = spl_valid;
	assign pop       = res_valid && !res_stall;

	crce_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.credit_ok (credit_ok),
		.ram       (ram),
		.iss       (iss)
	);

	// two identical copies of the store: p0/p1 from one, p2/p3 from the other
	crce_ram #(
		.WIDTH (crce_pkg::VAL_W),
		.DEPTH (crce_pkg::RAM_DEPTH)
	) u_ram_a (
		.clk     (clk),
		.we      (ram.we),
		.waddr   (ram.waddr),
		.wdata   (ram.wdata),
		.raddr_a (ram.raddr[0]),
		.raddr_b (ram.raddr[1]),
		.rdata_a (pts[0]),
		.rdata_b (pts[1])
	);

	crce_ram #(
		.WIDTH (crce_pkg::VAL_W),
		.DEPTH (crce_pkg::RAM_DEPTH)
	) u_ram_b (
		.clk     (clk),
		.we      (ram.we),
		.waddr   (ram.waddr),
		.wdata   (ram.wdata),
		.raddr_a (ram.raddr[2]),
		.raddr_b (ram.raddr[3]),
		.rdata_a (pts[2]),
		.rdata_b (pts[3])
	);

	crce_spline u_spline (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss       (iss),
		.pts       (pts),
		.out_valid (spl_valid),
		.out_item  (spl_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			fifo_cnt_q <= '0;
			used_q     <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + crce_pkg::OUT_PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + crce_pkg::OUT_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + crce_pkg::OUT_CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - crce_pkg::OUT_CNT_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			// reserve a slot per issued read, release it when the beat leaves
			case ({iss.valid, pop})
				2'b10:   used_q <= used_q + crce_pkg::OUT_CNT_W'(1);
				2'b01:   used_q <= used_q - crce_pkg::OUT_CNT_W'(1);
				default: used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= spl_item;
		end
	end

	assign res_valid = (fifo_cnt_q != '0);
	assign res       = fifo_q[rp_q];

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q != crce_pkg::OUT_CNT_W'(crce_pkg::OUT_DEPTH)) || pop)
		else $error("result buffer overflow");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= fifo_cnt_q)
		else $error("buffered results exceed reserved slots");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result beat changed or dropped");

endmodule

/* hdl/crce_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module crce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* hdl/crce_rem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_rem
// Restoring remainder unit: one numerator bit per cycle, over all sixteen bits.
// ----------------------------------------------------------------------------
module crce_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [crce_pkg::SEG_W-1:0]  num,
	input  logic [crce_pkg::CNT_W-1:0]  den,
	output logic                        done,
	output logic [crce_pkg::CNT_W-1:0]  rem
);

	localparam int STEP_W = $clog2(crce_pkg::SEG_W);

	logic                        run_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [crce_pkg::SEG_W-1:0]  num_q;
	logic [crce_pkg::CNT_W-1:0]  rem_q;
	logic [crce_pkg::CNT_W:0]    trial;
	logic [crce_pkg::CNT_W:0]    den_x;

	assign trial = {rem_q, num_q[crce_pkg::SEG_W-1]};
	assign den_x = {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(crce_pkg::SEG_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (trial >= den_x) begin
				rem_q <= crce_pkg::CNT_W'(trial - den_x);
			end else begin
				rem_q <= crce_pkg::CNT_W'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* hdl/crce_spline.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_spline
// Seven-stage Catmull-Rom datapath, one component per cycle, with one multiply
// in each of stages 3, 5 and 7.
// ----------------------------------------------------------------------------
module crce_spline (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crce_pkg::issue_t                   iss,
	input  logic [3:0][crce_pkg::VAL_W-1:0]    pts,
	output logic                               out_valid,
	output crce_pkg::out_item_t                out_item
);

	localparam int P_W   = crce_pkg::VAL_W + 4;
	localparam int A_W   = crce_pkg::VAL_W + 1;
	localparam int B_W   = crce_pkg::VAL_W + 4;
	localparam int C_W   = crce_pkg::VAL_W + 3;
	localparam int F_W   = crce_pkg::FRAC_W + 1;
	localparam int MC_W  = C_W + F_W;
	localparam int T2_W  = B_W + 1;
	localparam int MT_W  = T2_W + F_W;
	localparam int T1_W  = T2_W + 2;
	localparam int M1_W  = T1_W + F_W;
	localparam int ACC_W = M1_W + 1;
	localparam int SH    = crce_pkg::FRAC_W + 1;
	localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) <<< crce_pkg::FRAC_W;
	localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (crce_pkg::VAL_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	crce_pkg::issue_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	logic signed [P_W-1:0]    pw0, pw1, pw2, pw3;
	logic signed [A_W-1:0]    a_s2, a_s3, a_s4, a_s5;
	logic signed [B_W-1:0]    b_s2, b_s3;
	logic signed [C_W-1:0]    c_s2;
	logic signed [MC_W-1:0]   mc_s3;
	logic signed [T2_W-1:0]   t2_s4;
	logic signed [MT_W-1:0]   mt_s5;
	logic signed [T1_W-1:0]   t1_s6;
	logic signed [M1_W-1:0]   m1_s7;
	logic [crce_pkg::VAL_W-1:0] p1_s2, p1_s3, p1_s4, p1_s5, p1_s6, p1_s7;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_sh;
	logic [crce_pkg::VAL_W-1:0] sat_val;

	assign pw0 = P_W'($signed(pts[0]));
	assign pw1 = P_W'($signed(pts[1]));
	assign pw2 = P_W'($signed(pts[2]));
	assign pw3 = P_W'($signed(pts[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= iss.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		// s1 lines up with the registered RAM read
		meta_s1 <= iss;

		meta_s2 <= meta_s1;
		a_s2    <= A_W'(pw2 - pw0);
		b_s2    <= (pw0 <<< 1) - (pw1 <<< 2) - pw1 + (pw2 <<< 2) - pw3;
		c_s2    <= C_W'(pw1 + (pw1 <<< 1) - pw0 - pw2 - (pw2 <<< 1) + pw3);
		p1_s2   <= pts[1];

		meta_s3 <= meta_s2;
		mc_s3   <= c_s2 * $signed({1'b0, meta_s2.frac});
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		p1_s3   <= p1_s2;

		meta_s4 <= meta_s3;
		t2_s4   <= T2_W'(b_s3) + T2_W'(mc_s3 >>> crce_pkg::FRAC_W);
		a_s4    <= a_s3;
		p1_s4   <= p1_s3;

		meta_s5 <= meta_s4;
		mt_s5   <= t2_s4 * $signed({1'b0, meta_s4.frac});
		a_s5    <= a_s4;
		p1_s5   <= p1_s4;

		meta_s6 <= meta_s5;
		t1_s6   <= T1_W'(a_s5) + T1_W'(mt_s5 >>> crce_pkg::FRAC_W);
		p1_s6   <= p1_s5;

		meta_s7 <= meta_s6;
		m1_s7   <= t1_s6 * $signed({1'b0, meta_s6.frac});
		p1_s7   <= p1_s6;
	end

	// half of (2*p1 + t1*u), rounded half up, then clipped to 32 bits
	always_comb begin
		acc    = (ACC_W'($signed(p1_s7)) <<< SH) + ACC_W'(m1_s7) + ROUND;
		acc_sh = acc >>> SH;
		if (acc_sh > SAT_MAX) begin
			sat_val = crce_pkg::VAL_W'(SAT_MAX);
		end else if (acc_sh < SAT_MIN) begin
			sat_val = crce_pkg::VAL_W'(SAT_MIN);
		end else begin
			sat_val = crce_pkg::VAL_W'(acc_sh);
		end
	end

	assign out_valid              = valid_s7;
	assign out_item.out_component = meta_s7.comp;
	assign out_item.out_value     = meta_s7.copy ? p1_s7 : sat_val;
	assign out_item.last          = meta_s7.last;

endmodule

/* hdl/crce_ctl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_ctl
// Configuration registers, point store clearing and loading, parameter wrap
// and per-component read sequencing.
// ----------------------------------------------------------------------------
module crce_ctl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [crce_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  crce_pkg::in_item_t          cmd,
	input  logic                        credit_ok,
	output crce_pkg::ram_req_t          ram,
	output crce_pkg::issue_t            iss
);

	localparam int SEG_X = crce_pkg::SEG_W + 1;
	localparam int CNT_X = crce_pkg::CNT_W + 1;

	crce_pkg::state_t state_q, state_d;

	logic [crce_pkg::ADDR_W-1:0]      clr_addr_q;
	logic [crce_pkg::CNT_W-1:0]       count_q;
	logic [crce_pkg::DIMS_W-1:0]      dims_q;
	logic [crce_pkg::CNT_W-1:0]       cnt_eff, cnt_eff_q;
	logic [crce_pkg::DIMS_W-1:0]      dims_eff, dims_eff_q;
	logic                             copy_q;
	logic [crce_pkg::PT_W-1:0]        seg_q;
	logic [crce_pkg::FRAC_W-1:0]      frac_q;
	logic [3:0][crce_pkg::PT_W-1:0]   q_q;
	logic [crce_pkg::COMP_W-1:0]      d_q;

	logic                             accept;
	logic                             is_eval;
	logic signed [crce_pkg::SEG_W-1:0] seg_raw;
	logic                             in_range;
	logic                             use_curve;
	logic                             rem_start;
	logic [crce_pkg::SEG_W-1:0]       rem_num;
	logic                             rem_done;
	logic [crce_pkg::CNT_W-1:0]       rem_val;
	logic                             last_d;
	logic                             load_ok;
	logic [CNT_X-1:0]                 s1p, s2p;

	assign accept   = cmd_valid && !cmd_stall;
	assign is_eval  = (cmd.operation == crce_pkg::OP_EVAL);
	assign seg_raw  = cmd.param[crce_pkg::VAL_W-1:crce_pkg::FRAC_W];
	assign rem_num  = -seg_raw;

	assign cnt_eff  = (int'(count_q) > crce_pkg::MAX_POINTS) ?
		crce_pkg::CNT_W'(crce_pkg::MAX_POINTS) : count_q;
	assign dims_eff = (dims_q == '0) ? crce_pkg::DIMS_W'(1) :
		(int'(dims_q) > crce_pkg::DIM_LIM) ? crce_pkg::DIMS_W'(crce_pkg::DIM_LIM) : dims_q;

	// param below count*2^16 is the same as its integer part below count
	assign in_range  = $signed(SEG_X'(seg_raw)) < $signed(SEG_X'(cnt_eff));
	assign use_curve = (int'(cnt_eff) >= crce_pkg::MIN_LOOP) && in_range;
	assign rem_start = accept && is_eval && use_curve && seg_raw[crce_pkg::SEG_W-1];

	assign load_ok = (int'(cmd.point_index) < crce_pkg::MAX_POINTS) &&
		(int'(cmd.component_index) < crce_pkg::MAX_DIMS);

	assign last_d = ({1'b0, d_q} == (dims_eff_q - crce_pkg::DIMS_W'(1)));

	assign s1p = CNT_X'(seg_q) + CNT_X'(1);
	assign s2p = CNT_X'(seg_q) + CNT_X'(2);

	crce_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.num    (rem_num),
		.den    (cnt_eff_q),
		.done   (rem_done),
		.rem    (rem_val)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			crce_pkg::ST_CLEAR: begin
				if (clr_addr_q == crce_pkg::ADDR_W'(crce_pkg::RAM_DEPTH - 1)) begin
					state_d = crce_pkg::ST_IDLE;
				end
			end
			crce_pkg::ST_IDLE: begin
				if (accept && is_eval) begin
					state_d = rem_start ? crce_pkg::ST_WRAP : crce_pkg::ST_SETUP;
				end
			end
			crce_pkg::ST_WRAP: begin
				if (rem_done) begin
					state_d = crce_pkg::ST_SETUP;
				end
			end
			crce_pkg::ST_SETUP: begin
				state_d = crce_pkg::ST_ISSUE;
			end
			crce_pkg::ST_ISSUE: begin
				if (credit_ok && last_d) begin
					state_d = crce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crce_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_stall = 1'b1;
		ram.we    = 1'b0;
		ram.waddr = clr_addr_q;
		ram.wdata = '0;
		for (int i = 0; i < 4; i++) begin
			ram.raddr[i] = {q_q[i], crce_pkg::DIM_W'(d_q)};
		end
		iss.valid = 1'b0;
		iss.comp  = d_q;
		iss.last  = last_d;
		iss.copy  = copy_q || (int'(d_q) < crce_pkg::COPY_COMPS);
		iss.frac  = frac_q;
		case (state_q)
			crce_pkg::ST_CLEAR: begin
				ram.we = 1'b1;
			end
			crce_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid && !is_eval && load_ok) begin
					ram.we    = 1'b1;
					ram.waddr = {crce_pkg::PT_W'(cmd.point_index),
						crce_pkg::DIM_W'(cmd.component_index)};
					ram.wdata = cmd.load_value;
				end
			end
			crce_pkg::ST_ISSUE: begin
				iss.valid = credit_ok;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= crce_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			count_q    <= '0;
			dims_q     <= crce_pkg::DIMS_W'(crce_pkg::DIMS_RESET);
			d_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == crce_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + crce_pkg::ADDR_W'(1);
			end
			if (cfg_we) begin
				if (cfg_index == crce_pkg::CFG_POINT_COUNT) begin
					count_q <= cfg_data;
				end else begin
					dims_q <= cfg_data[crce_pkg::DIMS_W-1:0];
				end
			end
			if (accept && is_eval) begin
				d_q <= '0;
			end else if (state_q == crce_pkg::ST_ISSUE && credit_ok) begin
				d_q <= d_q + crce_pkg::COMP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_eval) begin
			cnt_eff_q  <= cnt_eff;
			dims_eff_q <= dims_eff;
			copy_q     <= !use_curve;
			frac_q     <= use_curve ? cmd.param[crce_pkg::FRAC_W-1:0] : '0;
			seg_q      <= (use_curve && !seg_raw[crce_pkg::SEG_W-1]) ?
				crce_pkg::PT_W'(seg_raw) : '0;
		end else if (state_q == crce_pkg::ST_WRAP && rem_done) begin
			// negative segment wraps upward: count minus the remainder
			seg_q <= (rem_val == '0) ? '0 : crce_pkg::PT_W'(cnt_eff_q - rem_val);
		end
		if (state_q == crce_pkg::ST_SETUP) begin
			if (copy_q) begin
				q_q <= '0;
			end else begin
				q_q[0] <= (seg_q == '0) ? crce_pkg::PT_W'(cnt_eff_q - crce_pkg::CNT_W'(1)) :
					seg_q - crce_pkg::PT_W'(1);
				q_q[1] <= seg_q;
				q_q[2] <= (s1p == CNT_X'(cnt_eff_q)) ? '0 : crce_pkg::PT_W'(s1p);
				q_q[3] <= (s2p >= CNT_X'(cnt_eff_q)) ?
					crce_pkg::PT_W'(s2p - CNT_X'(cnt_eff_q)) : crce_pkg::PT_W'(s2p);
			end
		end
	end

	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crce_pkg::ST_SETUP && !copy_q) |-> (CNT_X'(seg_q) < CNT_X'(cnt_eff_q)))
		else $error("wrapped segment not below point count");

	a_rem_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == crce_pkg::ST_WRAP))
		else $error("remainder finished outside the wrap state");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(iss.valid && iss.last) |=> (state_q == crce_pkg::ST_IDLE))
		else $error("final component issued but sequencer did not return to idle");

	a_no_wr_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crce_pkg::ST_ISSUE) |-> !ram.we)
		else $error("point store written while components are being read");

endmodule

/* dv/tb_closed_loop_catmull_rom_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closed_loop_catmull_rom_eval
// Self-checking bench for the closed-loop Catmull-Rom evaluator. Loads and
// evaluates are driven over the cmd channel with random gaps, the result
// channel is stalled at random, and every result beat is compared with a
// predicted component computed from a private copy of the point store.
// ----------------------------------------------------------------------------
module tb_closed_loop_catmull_rom_eval;

	import crce_pkg::*;

	localparam int          SETTLE_CYCLES = 40;
	localparam int          HOLD_CYCLES   = 400;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          MAX_REPORTS   = 40;

	localparam logic [11:0][31:0] CORNER_VALS = {
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
	};
	localparam logic [8:0][31:0] CORNER_PARAMS = {
		32'h0000_0000, 32'h0000_8000, 32'h0002_FFFF, 32'h0003_0000, 32'h7FFF_FFFF,
		32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFD_0000, 32'h0001_8000
	};

	class loop_spline_checker;
		int          point_words [RAM_DEPTH];
		int unsigned point_count;
		int unsigned dims;
		out_item_t   expected_beats [$];
		int          errors;
		int          loads;
		int          evals;
		int          beats;
		int          settings;

		function new();
			foreach (point_words[i]) point_words[i] = 0;
			point_count = 0;
			dims        = DIMS_RESET;
		endfunction

		function void set_regs(int unsigned count, int unsigned nd);
			point_count = count & 32'h1FF;
			dims        = nd & 32'h1F;
			settings++;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function logic [31:0] interp(longint p0, longint p1, longint p2, longint p3,
			longint f);
			longint a, b, c, t2, t1, acc, v;
			a   = p2 - p0;
			b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
			c   = -p0 + 3 * p1 - 3 * p2 + p3;
			t2  = b + ((c * f) >>> 16);
			t1  = a + ((t2 * f) >>> 16);
			acc = p1 * 131072 + t1 * f + 65536;
			v   = acc >>> 17;
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		function longint word_at(int unsigned pt, int unsigned d);
			return longint'(point_words[pt * MAX_DIMS + d]);
		endfunction

		// Note an accepted cmd beat: update the store or queue the components.
		function void note_input(in_item_t it);
			int unsigned n, nd, seg, q0, q1, q2, q3, d;
			longint      m, p, w, f;
			bit          copy_p0;
			out_item_t   r;
			if (it.operation == OP_LOAD) begin
				point_words[it.point_index * MAX_DIMS + it.component_index] =
					$signed(it.load_value);
				loads++;
				return;
			end
			evals++;
			n  = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
			nd = (dims < 1) ? 1 : ((dims > DIM_LIM) ? DIM_LIM : dims);
			copy_p0 = 1'b1;
			f  = 0;
			q0 = 0; q1 = 0; q2 = 0; q3 = 0;
			if (n >= MIN_LOOP) begin
				m = longint'(n) * 65536;
				p = longint'($signed(it.param));
				if (p < m) begin
					// wrap negative parameters upward
					w = p % m;
					if (w < 0) w += m;
					seg = int'(w >>> 16);
					f   = w & 64'hFFFF;
					q0  = (seg + n - 1) % n;
					q1  = seg;
					q2  = (seg + 1) % n;
					q3  = (seg + 2) % n;
					copy_p0 = 1'b0;
				end
			end
			for (d = 0; d < nd; d++) begin
				r.out_component = d[COMP_W-1:0];
				r.last          = (d + 1 == nd);
				if (copy_p0)
					r.out_value = 32'(word_at(0, d));
				else if (d < COPY_COMPS)
					r.out_value = 32'(word_at(q1, d));
				else
					r.out_value = interp(word_at(q0, d), word_at(q1, d), word_at(q2, d),
						word_at(q3, d), f);
				expected_beats.push_back(r);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			beats++;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat comp %0d value %h last %b",
					got.out_component, got.out_value, got.last));
				return;
			end
			want = expected_beats.pop_front();
			if (got.out_component !== want.out_component)
				report_mismatch($sformatf("out_component %0d, want %0d",
					got.out_component, want.out_component));
			if (got.out_value !== want.out_value)
				report_mismatch($sformatf("comp %0d out_value %h, want %h",
					want.out_component, got.out_value, want.out_value));
			if (got.last !== want.last)
				report_mismatch($sformatf("comp %0d last %b, want %b",
					want.out_component, got.last, want.last));
		endtask

		task check_leftovers();
			if (expected_beats.size() != 0)
				report_mismatch($sformatf("%0d expected beats never arrived",
					expected_beats.size()));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CNT_W-1:0]    cfg_data;
	logic                cmd_valid;
	logic                cmd_stall;
	in_item_t            cmd;
	logic                res_valid;
	logic                res_stall;
	out_item_t           res;

	bit                  quiet;
	bit                  hold_req;
	loop_spline_checker  sb;

	closed_loop_catmull_rom_eval DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			res_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 24);
			if (hold_left > 0) hold_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) sb.note_input(cmd);
			if (res_valid && !res_stall) sb.check_result(res);
		end
	end

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return 32'h7FFF_FFFF;
		if (sel == 1) return 32'h8000_0000;
		if (sel < 5) return 32'($urandom_range(32'h3FFFF)) - 32'h2_0000;
		return $urandom;
	endfunction

	function automatic in_item_t load_item(int unsigned pt, int unsigned ci,
		logic [31:0] v);
		in_item_t it;
		it.operation       = OP_LOAD;
		it.point_index     = pt[PIDX_W-1:0];
		it.component_index = ci[COMP_W-1:0];
		it.load_value      = v;
		it.param           = $urandom;
		return it;
	endfunction

	function automatic in_item_t eval_item(logic [31:0] prm);
		in_item_t it;
		it.operation       = OP_EVAL;
		it.point_index     = PIDX_W'($urandom);
		it.component_index = COMP_W'($urandom);
		it.load_value      = $urandom;
		it.param           = prm;
		return it;
	endfunction

	// Mostly loads into the live loop and parameters inside it; some noise.
	function automatic in_item_t random_item(int unsigned count);
		int unsigned span, pt;
		int          sel;
		logic [31:0] prm;
		span = (count > MAX_POINTS) ? MAX_POINTS : ((count < MIN_LOOP) ? 4 : count);
		if ($urandom_range(99) < 40) begin
			pt = ($urandom_range(9) == 0) ? $urandom_range(MAX_POINTS - 1)
				: $urandom_range(span - 1);
			return load_item(pt, $urandom_range(MAX_DIMS - 1), pick_value());
		end
		sel = $urandom_range(9);
		if (sel < 6)
			prm = $urandom_range(span * 65536 - 1);
		else if (sel < 8)
			prm = -32'($urandom_range(span * 65536));
		else if (sel == 8)
			prm = span * 65536 - 2 + $urandom_range(3);
		else
			prm = $urandom;
		return eval_item(prm);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_item(input in_item_t it);
		while (!quiet && $urandom_range(99) < 24) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd       <= it;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic write_config(input int unsigned count, input int unsigned nd);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_POINT_COUNT;
		cfg_data  <= count[CNT_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_DIMS;
		cfg_data  <= CNT_W'(nd);
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_regs(count, nd);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned nd,
		input int n_items, input bit no_idle, input bit hold_off, input bit pause);
		write_config(count, nd);
		quiet = no_idle;
		if (hold_off) hold_req = 1'b1;
		repeat (n_items) begin
			send_item(random_item(count));
			if (pause && $urandom_range(19) == 0) wait_results_done();
		end
		wait_results_done();
		quiet = 1'b0;
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int i;
		sb        = new();
		quiet     = 1'b0;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_POINT_COUNT;
		cfg_data  = '0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: three-point loop, corner values and parameters
		write_config(3, 4);
		for (i = 0; i < 12; i++) send_item(load_item(i / 4, i % 4, CORNER_VALS[i]));
		send_item(load_item(MAX_POINTS - 1, MAX_DIMS - 1, 32'hFFFF_FFFF));
		for (i = 0; i < 9; i++) send_item(eval_item(CORNER_PARAMS[i]));
		wait_results_done();
		repeat (SETTLE_CYCLES) @(negedge clk);

		run_phase(4, 16, 60, 1'b0, 1'b0, 1'b1);
		run_phase(5, 6, 60, 1'b1, 1'b0, 1'b0);
		run_phase(256, 16, 40, 1'b0, 1'b0, 1'b0);
		run_phase(3, 3, 50, 1'b0, 1'b1, 1'b0);
		run_phase(0, 0, 15, 1'b0, 1'b0, 1'b0);
		run_phase(2, 20, 15, 1'b0, 1'b0, 1'b0);
		run_phase(300, 2, 30, 1'b0, 1'b0, 1'b0);
		run_phase(1, 1, 10, 1'b0, 1'b0, 1'b0);
		run_phase(7, 9, 60, 1'b0, 1'b0, 1'b1);

		sb.check_leftovers();
		$display("Run covered %0d loads and %0d evaluations (%0d result beats)",
			sb.loads, sb.evals, sb.beats);
		$display("over %0d register settings, with stalls, a long hold-off and pauses",
			sb.settings);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/crce_pkg.sv
hdl/crce_ram.sv
hdl/crce_rem.sv
hdl/crce_spline.sv
hdl/crce_ctl.sv
hdl/closed_loop_catmull_rom_eval.sv
dv/tb_closed_loop_catmull_rom_eval.sv
